// ----- rtl/spq_pkg.sv -----
package spq_pkg;

  // Number of entries the queue holds
  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam int PAYLOAD_W = 32;
  localparam int RANK_W    = 16;
  localparam int OCC_W     = 5;
  localparam int STATUS_W  = 2;

  // Operation codes
  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_POP_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_PUSH_FULL = 2'd2;

  typedef struct packed {
    logic signed [PAYLOAD_W-1:0] payload;
    logic        [RANK_W-1:0]    rank;
  } entry_t;

  // Per-cycle command broadcast to every cell
  typedef struct packed {
    logic push;
    logic pop;
  } ctrl_t;

endpackage

// ----- rtl/spq_cell.sv -----
module spq_cell (
  input  logic            clk,
  input  spq_pkg::ctrl_t  ctrl,
  input  spq_pkg::entry_t new_entry,
  input  spq_pkg::entry_t left_entry,
  input  logic            left_ge,
  input  spq_pkg::entry_t right_entry,
  input  logic            valid,
  output spq_pkg::entry_t entry,
  output logic            ge
);
  import spq_pkg::*;

  // Flag this slot as at or behind the insertion point
  assign ge = !valid || (entry.rank >= new_entry.rank);

  // On push, shift right from the insertion point and load the new entry there;
  // on pop, take the right neighbor's entry
  always_ff @(posedge clk) begin
    if (ctrl.push && ge) begin
      entry <= left_ge ? left_entry : new_entry;
    end else if (ctrl.pop) begin
      entry <= right_entry;
    end
  end

endmodule

// ----- rtl/sorted_priority_queue.sv -----
// Sorted minimum priority queue of spq_pkg::CAPACITY entries, held in a row of
// cells in ascending rank order, so the lowest rank is served first and among
// equal ranks the newest entry. Every cell compares the broadcast rank with its
// own in parallel, so one push or pop is taken per clock cycle: busy stays low,
// and the result of an item appears on the result ports, marked by done, in the
// cycle right after the item was taken. The result is shown for that one cycle
// only; the receiver cannot stall it and must capture it when done is high.
// A push to a full queue and a pop from an empty one are reported in status
// and leave the queue unchanged.
module sorted_priority_queue (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  output logic                                   busy,
  input  logic                                   kind,
  input  logic signed [spq_pkg::PAYLOAD_W-1:0]   payload,
  input  logic        [spq_pkg::RANK_W-1:0]      rank,
  output logic                                   done,
  output logic signed [spq_pkg::PAYLOAD_W-1:0]   popped_payload,
  output logic                                   popped_valid,
  output logic        [spq_pkg::STATUS_W-1:0]    status,
  output logic signed [spq_pkg::PAYLOAD_W-1:0]   head_payload,
  output logic                                   is_empty,
  output logic        [spq_pkg::OCC_W-1:0]       occupancy
);
  import spq_pkg::*;

  logic             accept;
  logic             full;
  logic             empty;
  ctrl_t            ctrl;
  entry_t           new_entry;
  entry_t           cells   [CAPACITY];
  logic             ge      [CAPACITY];
  logic             valid   [CAPACITY];
  entry_t           right_in[CAPACITY];
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic signed [PAYLOAD_W-1:0] head_next;
  logic [STATUS_W-1:0]         status_next;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (count == CNT_W'(CAPACITY));
  assign empty  = (count == '0);

  assign ctrl.push = accept && (kind == KIND_PUSH) && !full;
  assign ctrl.pop  = accept && (kind == KIND_POP) && !empty;

  assign new_entry.payload = payload;
  assign new_entry.rank    = rank;

  // Build the row of cells; slot 0 is the head
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign valid[i] = (CNT_W'(i) < count);

    if (i == CAPACITY - 1) begin : g_last
      assign right_in[i] = '0;
    end else begin : g_mid
      assign right_in[i] = cells[i+1];
    end

    if (i == 0) begin : g_head
      spq_cell u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .new_entry  (new_entry),
        .left_entry (new_entry),
        .left_ge    (1'b0),
        .right_entry(right_in[i]),
        .valid      (valid[i]),
        .entry      (cells[i]),
        .ge         (ge[i])
      );
    end else begin : g_body
      spq_cell u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .new_entry  (new_entry),
        .left_entry (cells[i-1]),
        .left_ge    (ge[i-1]),
        .right_entry(right_in[i]),
        .valid      (valid[i]),
        .entry      (cells[i]),
        .ge         (ge[i])
      );
    end
  end

  // Track the fill count
  always_comb begin
    count_next = count;
    if (ctrl.push) begin
      count_next = count + 1'b1;
    end else if (ctrl.pop) begin
      count_next = count - 1'b1;
    end
  end

  // Head after the operation, taken from the cells' next values
  always_comb begin
    if (ctrl.pop) begin
      head_next = (CAPACITY > 1) ? right_in[0].payload : '0;
    end else if (ctrl.push && ge[0]) begin
      head_next = payload;
    end else begin
      head_next = cells[0].payload;
    end
    if (count_next == '0) begin
      head_next = '0;
    end
  end

  always_comb begin
    status_next = ST_OK;
    if (accept && (kind == KIND_PUSH) && full) begin
      status_next = ST_PUSH_FULL;
    end else if (accept && (kind == KIND_POP) && empty) begin
      status_next = ST_POP_EMPTY;
    end
  end

  // Advance control state
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      done  <= accept;
    end
  end

  // Register the result of each transfer
  always_ff @(posedge clk) begin
    popped_payload <= ctrl.pop ? cells[0].payload : '0;
    popped_valid   <= ctrl.pop;
    status         <= status_next;
    head_payload   <= head_next;
    is_empty       <= (count_next == '0);
    occupancy      <= OCC_W'(count_next);
  end

endmodule
